@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RQA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RQA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/rqa_pkg.sv @@
// ---------------------------------------------------------------------------
// rqa_pkg
// Shared types, widths and codes of the RED queue admission block.
// ---------------------------------------------------------------------------
package rqa_pkg;

  localparam int QUEUE_DEPTH    = 64;
  localparam int MAX_IDLE_STEPS = 255;

  localparam int AVG_W   = 23;                       // Q7.16 average
  localparam int FRAC_W  = 16;
  localparam int OCC_W   = 7;
  localparam int THR_W   = 7;
  localparam int Q16_W   = 16;
  localparam int SD_W    = 9;                        // signed, -1..255
  localparam int STEP_W  = $clog2(MAX_IDLE_STEPS + 1);
  localparam int MUL_A_W = 23;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // serial divider: Q16 numerator over threshold span
  localparam int DIV_W     = AVG_W;
  localparam int DIVR_W    = THR_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam logic [16:0]      ONE_Q16 = 17'h10000;

  // decision codes
  localparam logic [1:0] DEC_BUFFER    = 2'd0;
  localparam logic [1:0] DEC_EARLY     = 2'd1;
  localparam logic [1:0] DEC_ABOVE_MAX = 2'd2;
  localparam logic [1:0] DEC_FULL      = 2'd3;

  // operation codes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_WEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROB     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCED_CNT   = 3'd4;

  // configuration reset values
  localparam logic [15:0] RST_QUEUE_WEIGHT = 16'd197;
  localparam logic [6:0]  RST_MIN_THR      = 7'd5;
  localparam logic [6:0]  RST_MAX_THR      = 7'd17;
  localparam logic [15:0] RST_MAX_PROB     = 16'd1311;
  localparam logic [7:0]  RST_FORCED_CNT   = 8'd50;

  typedef struct packed {
    logic        op;
    logic [7:0]  payload;
    logic [31:0] now_time;
    logic [6:0]  rand_pct;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       decision;
    logic [7:0]       payload_out;
    logic [OCC_W-1:0] queue_len;
    logic [AVG_W-1:0] avg_len;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ sv/rqa_mul_unit.sv @@
// ---------------------------------------------------------------------------
// rqa_mul_unit
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module rqa_mul_unit import rqa_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] mul_a,
  input  logic [MUL_B_W-1:0] mul_b,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

@@ sv/rqa_div_unit.sv @@
// ---------------------------------------------------------------------------
// rqa_div_unit
// Restoring divider, one quotient bit per cycle, done pulses when finished.
// ---------------------------------------------------------------------------
module rqa_div_unit import rqa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     work_r;      // dividend shifts out, quotient shifts in
  logic [DIVR_W-1:0]    rem_r;
  logic [DIVR_W-1:0]    divisor_r;

  logic [DIVR_W:0] rem_sh;
  logic [DIVR_W:0] rem_dif;
  logic            ge;

  always_comb begin
    rem_sh  = {rem_r, work_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, divisor_r};
    rem_dif = rem_sh - {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r    <= 1'b1;
        cnt_r     <= DIV_CNT_W'(DIV_W);
        work_r    <= div_req.dividend;
        rem_r     <= '0;
        divisor_r <= div_req.divisor;
      end else if (busy_r) begin
        work_r <= {work_r[DIV_W-2:0], ge};
        rem_r  <= ge ? rem_dif[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
        cnt_r  <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.done     = done_r;
  assign div_rsp.quotient = work_r;

endmodule

@@ sv/red_queue_admission.sv @@
// ---------------------------------------------------------------------------
// red_queue_admission
// Random early detection admission for one queue, one item at a time.
// ---------------------------------------------------------------------------
// An item is taken only while the sequencer is idle; its single result goes
// to an output register, so the next item can be taken while that result
// waits. All products go through one registered multiplier, and the drop
// probability comes from a one-bit-per-cycle divider. A flush skips the
// average update; an arrival on an empty queue first decays the average once
// per idle second, at most MAX_IDLE_STEPS (255) times.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module red_queue_admission import rqa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECAY   = 4'd1;
  localparam logic [3:0] S_DECAY_W = 4'd2;
  localparam logic [3:0] S_EWMA1   = 4'd3;
  localparam logic [3:0] S_EWMA2   = 4'd4;
  localparam logic [3:0] S_EWMA3   = 4'd5;
  localparam logic [3:0] S_CLASS   = 4'd6;
  localparam logic [3:0] S_PB1     = 4'd7;
  localparam logic [3:0] S_PB2     = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_DEN1    = 4'd10;
  localparam logic [3:0] S_DEN2    = 4'd11;
  localparam logic [3:0] S_CMP1    = 4'd12;
  localparam logic [3:0] S_CMP2    = 4'd13;
  localparam logic [3:0] S_ADMIT   = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  // control and state registers
  logic [3:0]              state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             wq_r, wq_nxt;
  logic [THR_W-1:0]        min_r, min_nxt;
  logic [THR_W-1:0]        max_r, max_nxt;
  logic [15:0]             maxp_r, maxp_nxt;
  logic [7:0]              fdc_r, fdc_nxt;
  logic [AVG_W-1:0]        avg_r, avg_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  logic signed [SD_W-1:0]  sd_r, sd_nxt;
  logic [31:0]             idle_r, idle_nxt;

  // working registers
  in_item_t                item_r, item_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  logic [PROD_W-1:0]       acc_r, acc_nxt;
  logic [Q16_W-1:0]        pb_r, pb_nxt;
  logic [16:0]             denom_r, denom_nxt;
  logic [1:0]              verdict_r, verdict_nxt;
  logic [1:0]              dec_r, dec_nxt;
  logic [7:0]              pay_r, pay_nxt;

  // shared units
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  // datapath terms
  logic                    in_fire;
  logic [16:0]             keep;
  logic [AVG_W-1:0]        lo;
  logic [AVG_W-1:0]        hi;
  logic                    in_band;
  logic signed [SD_W-1:0]  sd_inc;
  logic                    forced;
  logic                    span_bad;
  logic [THR_W-1:0]        span;
  logic [AVG_W-1:0]        diff;
  logic [AVG_W+1:0]        ewma_sum;
  logic [AVG_W-1:0]        ewma_sat;
  logic [31:0]             idle_diff;
  logic [STEP_W-1:0]       steps_cap;
  logic                    sp_over;
  logic [16:0]             denom;
  logic                    pb_ge;
  logic [AVG_W-1:0]        pb100;
  logic                    rand_hit;

  rqa_mul_unit u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  rqa_div_unit u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    keep      = ONE_Q16 - {1'b0, wq_r};
    lo        = {min_r, {FRAC_W{1'b0}}};
    hi        = {max_r, {FRAC_W{1'b0}}};
    in_band   = (avg_r >= lo) && (avg_r < hi);
    sd_inc    = (sd_r == SD_W'(255)) ? sd_r : sd_r + SD_W'(1);
    // in the band the counter is never negative after the increment
    forced    = sd_inc[7:0] >= fdc_r;
    span_bad  = (max_r <= min_r);
    span      = max_r - min_r;
    diff      = avg_r - lo;
    // (avg*keep + wq*(occ<<16)) >> 16, low half of the second term is zero
    ewma_sum  = {1'b0, acc_r[PROD_W-1:FRAC_W]} + {2'b0, prod[AVG_W-1:0]};
    ewma_sat  = (ewma_sum > {2'b0, AVG_MAX}) ? AVG_MAX : ewma_sum[AVG_W-1:0];
    idle_diff = in_data.now_time - idle_r;
    steps_cap = (idle_diff > 32'(MAX_IDLE_STEPS)) ? STEP_W'(MAX_IDLE_STEPS)
                                                  : idle_diff[STEP_W-1:0];
    sp_over   = |prod[PROD_W-1:16];
    denom     = ONE_Q16 - prod[16:0];
    pb_ge     = {1'b0, pb_r} >= denom;
    pb100     = ({7'b0, pb_r} << 6) + ({7'b0, pb_r} << 5) + ({7'b0, pb_r} << 2);
    rand_hit  = prod < PROD_W'(pb100);
  end

  // multiplier operand select
  always_comb begin
    mul_a = avg_r;
    mul_b = keep;
    unique case (state_r)
      S_EWMA2: begin
        mul_a = MUL_A_W'(occ_r);
        mul_b = MUL_B_W'(wq_r);
      end
      S_PB1: begin
        mul_a = diff;
        mul_b = MUL_B_W'(maxp_r);
      end
      S_DEN1: begin
        mul_a = MUL_A_W'(sd_r[7:0]);
        mul_b = MUL_B_W'(pb_r);
      end
      S_CMP1: begin
        mul_a = MUL_A_W'(item_r.rand_pct);
        mul_b = denom_r;
      end
      default: begin
        mul_a = avg_r;
        mul_b = keep;
      end
    endcase
  end

  assign div_req.start    = (state_r == S_PB2);
  assign div_req.dividend = prod[FRAC_W+AVG_W-1:FRAC_W];
  assign div_req.divisor  = span;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wq_nxt        = wq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    maxp_nxt      = maxp_r;
    fdc_nxt       = fdc_r;
    avg_nxt       = avg_r;
    occ_nxt       = occ_r;
    sd_nxt        = sd_r;
    idle_nxt      = idle_r;
    item_nxt      = item_r;
    steps_nxt     = steps_r;
    acc_nxt       = acc_r;
    pb_nxt        = pb_r;
    denom_nxt     = denom_r;
    verdict_nxt   = verdict_r;
    dec_nxt       = dec_r;
    pay_nxt       = pay_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_QUEUE_WEIGHT: wq_nxt   = cfg_wdata;
        CFG_MIN_THR:      min_nxt  = cfg_wdata[THR_W-1:0];
        CFG_MAX_THR:      max_nxt  = cfg_wdata[THR_W-1:0];
        CFG_MAX_PROB:     maxp_nxt = cfg_wdata;
        CFG_FORCED_CNT:   fdc_nxt  = cfg_wdata[7:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          if (in_data.op == OP_FLUSH) begin
            occ_nxt   = '0;
            dec_nxt   = DEC_BUFFER;
            pay_nxt   = '0;
            state_nxt = S_OUT;
          end else if (occ_r == '0) begin
            steps_nxt = steps_cap;
            idle_nxt  = in_data.now_time;
            state_nxt = S_DECAY;
          end else begin
            state_nxt = S_EWMA1;
          end
        end
      end
      S_DECAY: begin
        if (steps_r == '0 || avg_r == '0) begin
          state_nxt = S_CLASS;
        end else begin
          state_nxt = S_DECAY_W;
        end
      end
      S_DECAY_W: begin
        avg_nxt   = prod[FRAC_W+AVG_W-1:FRAC_W];
        steps_nxt = steps_r - STEP_W'(1);
        state_nxt = S_DECAY;
      end
      S_EWMA1: begin
        state_nxt = S_EWMA2;
      end
      S_EWMA2: begin
        acc_nxt   = prod;
        state_nxt = S_EWMA3;
      end
      S_EWMA3: begin
        avg_nxt   = ewma_sat;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        verdict_nxt = DEC_BUFFER;
        state_nxt   = S_ADMIT;
        if (in_band) begin
          sd_nxt = sd_inc;
          if (forced || span_bad) begin
            verdict_nxt = DEC_EARLY;
          end else begin
            state_nxt = S_PB1;
          end
        end else if (avg_r >= hi) begin
          verdict_nxt = DEC_ABOVE_MAX;
        end
      end
      S_PB1: begin
        state_nxt = S_PB2;
      end
      S_PB2: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          pb_nxt    = div_rsp.quotient[Q16_W-1:0];
          state_nxt = S_DEN1;
        end
      end
      S_DEN1: begin
        state_nxt = S_DEN2;
      end
      S_DEN2: begin
        // denominator not positive, or probability already at one
        if (sp_over || pb_ge) begin
          verdict_nxt = DEC_EARLY;
          state_nxt   = S_ADMIT;
        end else begin
          denom_nxt = denom;
          state_nxt = S_CMP1;
        end
      end
      S_CMP1: begin
        state_nxt = S_CMP2;
      end
      S_CMP2: begin
        verdict_nxt = rand_hit ? DEC_EARLY : DEC_BUFFER;
        state_nxt   = S_ADMIT;
      end
      S_ADMIT: begin
        pay_nxt = '0;
        if (verdict_r == DEC_BUFFER) begin
          if (occ_r >= OCC_W'(QUEUE_DEPTH)) begin
            dec_nxt = DEC_FULL;
            sd_nxt  = '0;
          end else begin
            dec_nxt = DEC_BUFFER;
            occ_nxt = occ_r + OCC_W'(1);
            pay_nxt = item_r.payload;
            sd_nxt  = -SD_W'(1);
          end
        end else begin
          dec_nxt = verdict_r;
          sd_nxt  = '0;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.decision    = dec_r;
          out_data_nxt.payload_out = pay_r;
          out_data_nxt.queue_len   = occ_r;
          out_data_nxt.avg_len     = avg_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wq_r        <= RST_QUEUE_WEIGHT;
      min_r       <= RST_MIN_THR;
      max_r       <= RST_MAX_THR;
      maxp_r      <= RST_MAX_PROB;
      fdc_r       <= RST_FORCED_CNT;
      avg_r       <= '0;
      occ_r       <= '0;
      sd_r        <= -SD_W'(1);
      idle_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wq_r        <= wq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      maxp_r      <= maxp_nxt;
      fdc_r       <= fdc_nxt;
      avg_r       <= avg_nxt;
      occ_r       <= occ_nxt;
      sd_r        <= sd_nxt;
      idle_r      <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    item_r     <= item_nxt;
    steps_r    <= steps_nxt;
    acc_r      <= acc_nxt;
    pb_r       <= pb_nxt;
    denom_r    <= denom_nxt;
    verdict_r  <= verdict_nxt;
    dec_r      <= dec_nxt;
    pay_r      <= pay_nxt;
  end

  `RQA_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after input transfer")
  `RQA_ASSERT_SAME(a_occ_bound, 1'b1, occ_r <= OCC_W'(QUEUE_DEPTH), "occupancy above queue depth")
  `RQA_ASSERT_SAME(a_div_done_in_wait, div_rsp.done, state_r == S_DIV, "divider done outside wait")
  `RQA_ASSERT_NEXT(a_avg_hold_idle, state_r == S_IDLE, $stable(avg_r), "average changed while idle")

endmodule
